// ===== hw/rtl/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths, register indexes and structures of the temporal pixel
// accumulator.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int PIXELS_MAX = 65536;
  localparam int ADDR_W     = $clog2(PIXELS_MAX);
  localparam int FRAME_W    = ADDR_W + 1;
  localparam int COLOR_W    = 16;
  localparam int NORM_W     = 16;
  localparam int DEPTH_W    = 24;
  localparam int CNT_W      = 16;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_NUM_W  = CNT_W + 2;
  localparam int DIV_DEN_W  = CNT_W + 1;
  localparam int DIV_STEPS  = DIV_NUM_W;

  localparam logic [CFG_IDX_W-1:0] REG_HIST_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TOLERANCE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS     = 2'd3;

  localparam logic [CNT_W-1:0]   RST_HIST_LIMIT       = 16'd32;
  localparam logic [NORM_W-1:0]  RST_NORMAL_THRESHOLD = 16'd14746;
  localparam logic [CNT_W-1:0]   RST_DEPTH_TOLERANCE  = 16'd410;
  localparam logic [FRAME_W-1:0] RST_FRAME_PIXELS     = FRAME_W'(PIXELS_MAX);

  typedef struct packed {
    logic [ADDR_W-1:0]         addr;
    logic                      last;
    logic                      hv;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic [DEPTH_W-1:0]        depth;
    logic                      guides;
  } pix_t;

  typedef struct packed {
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic [DEPTH_W-1:0]        depth;
    logic                      guides;
    logic [CNT_W-1:0]          samples;
  } hist_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]          hist_limit;
    logic signed [NORM_W-1:0]  normal_threshold;
    logic [CNT_W-1:0]          depth_tolerance;
  } guide_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } stage_tag_t;

  typedef struct packed {
    pix_t               pix;
    logic [COLOR_W-1:0] hred;
    logic [COLOR_W-1:0] hgreen;
    logic [COLOR_W-1:0] hblue;
    logic               accept;
    logic [CNT_W-1:0]   count;
  } blend_t;

  typedef struct packed {
    pix_t               pix;
    logic [COLOR_W-1:0] bred;
    logic [COLOR_W-1:0] bgreen;
    logic [COLOR_W-1:0] bblue;
    logic [2:0]         dir;
    logic               accept;
    logic [CNT_W-1:0]   count;
  } side_t;

endpackage

// ===== hw/rtl/tpa_history_ram.sv =====
// ----------------------------------------------------------------------------
// tpa_history_ram
// Per-pixel history store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tpa_history_ram (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [tpa_pkg::ADDR_W-1:0] rd_addr,
  output tpa_pkg::hist_entry_t      rd_data,
  input  logic                      wr_en,
  input  logic [tpa_pkg::ADDR_W-1:0] wr_addr,
  input  tpa_pkg::hist_entry_t      wr_data
);
  import tpa_pkg::*;

  hist_entry_t mem [PIXELS_MAX];
  hist_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/tpa_guide_test.sv =====
// ----------------------------------------------------------------------------
// tpa_guide_test
// Two-stage history test: normal products and depth bound, then the
// dot product compare, acceptance and the saturated sample count.
// ----------------------------------------------------------------------------
module tpa_guide_test (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  tpa_pkg::pix_t         in_pix,
  input  tpa_pkg::hist_entry_t  in_hist,
  input  tpa_pkg::guide_cfg_t   cfg,
  output tpa_pkg::stage_tag_t   tag_b,
  output logic                  res_vld,
  output tpa_pkg::blend_t       res
);
  import tpa_pkg::*;

  logic                     b_valid_r;
  pix_t                     b_pix_r;
  logic [COLOR_W-1:0]       b_hred_r, b_hgreen_r, b_hblue_r;
  logic [CNT_W-1:0]         b_samples_r;
  logic                     b_gate_r, b_nchk_r, b_dchk_r;
  logic signed [31:0]       b_p0_r, b_p1_r, b_p2_r;
  logic [DEPTH_W+11:0]      b_diff_r;
  logic [DEPTH_W+15:0]      b_tolmx_r;
  logic                     c_valid_r;
  blend_t                   c_res_r;

  logic                     cn, hn;
  logic [DEPTH_W-1:0]       diff, mx;
  logic signed [31:0]       p0, p1, p2;
  logic signed [33:0]       dot, thr_ext;
  logic signed [16:0]       thr;
  logic                     acc;
  logic [CNT_W:0]           hcnt, maxh;
  logic [CNT_W-1:0]         cnt;

  always_comb begin
    cn   = (in_pix.nx != 0) || (in_pix.ny != 0) || (in_pix.nz != 0);
    hn   = (in_hist.nx != 0) || (in_hist.ny != 0) || (in_hist.nz != 0);
    p0   = $signed(in_pix.nx) * $signed(in_hist.nx);
    p1   = $signed(in_pix.ny) * $signed(in_hist.ny);
    p2   = $signed(in_pix.nz) * $signed(in_hist.nz);
    diff = (in_pix.depth > in_hist.depth) ? in_pix.depth - in_hist.depth
                                          : in_hist.depth - in_pix.depth;
    mx   = (in_pix.depth > in_hist.depth) ? in_pix.depth : in_hist.depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= in_vld;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pix_r     <= in_pix;
      b_hred_r    <= in_hist.red;
      b_hgreen_r  <= in_hist.green;
      b_hblue_r   <= in_hist.blue;
      b_samples_r <= in_hist.samples;
      b_gate_r    <= in_pix.hv && in_pix.guides && in_hist.guides;
      b_nchk_r    <= cn && hn;
      b_dchk_r    <= (in_pix.depth != 0) && (in_hist.depth != 0);
      b_p0_r      <= p0;
      b_p1_r      <= p1;
      b_p2_r      <= p2;
      b_diff_r    <= {diff, 12'b0};
      b_tolmx_r   <= {{DEPTH_W{1'b0}}, cfg.depth_tolerance} * {{CNT_W{1'b0}}, mx};
    end
  end

  always_comb begin
    dot = 34'(b_p0_r) + 34'(b_p1_r) + 34'(b_p2_r);
    if (cfg.normal_threshold > 16'sd16384) begin
      thr = 17'sd16384;
    end else if (cfg.normal_threshold < -16'sd16384) begin
      thr = -17'sd16384;
    end else begin
      thr = 17'(cfg.normal_threshold);
    end
    thr_ext = 34'(thr) <<< 14;
    acc = b_gate_r && (!b_nchk_r || (dot >= thr_ext)) &&
          !(b_dchk_r && ({4'b0, b_diff_r} > b_tolmx_r));
    maxh = (cfg.hist_limit == 0) ? 17'd1 : {1'b0, cfg.hist_limit};
    hcnt = {1'b0, b_samples_r} + 17'd1;
    if (hcnt > maxh) begin
      hcnt = maxh;
    end
    cnt = acc ? hcnt[CNT_W-1:0] : 16'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_res_r.pix    <= b_pix_r;
      c_res_r.hred   <= b_hred_r;
      c_res_r.hgreen <= b_hgreen_r;
      c_res_r.hblue  <= b_hblue_r;
      c_res_r.accept <= acc;
      c_res_r.count  <= cnt;
    end
  end

  assign tag_b.valid = b_valid_r;
  assign tag_b.addr  = b_pix_r.addr;
  assign res_vld     = c_valid_r;
  assign res         = c_res_r;

endmodule

// ===== hw/rtl/tpa_divider.sv =====
// ----------------------------------------------------------------------------
// tpa_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tpa_divider (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tpa_pkg::DIV_NUM_W-1:0]  num,
  input  logic [tpa_pkg::DIV_DEN_W-1:0]  den,
  output logic [tpa_pkg::CNT_W-1:0]      quo
);
  import tpa_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r [DIV_STEPS];
  logic [DIV_NUM_W-1:0] nq_r  [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    logic [DIV_DEN_W-1:0] rem_i;
    logic [DIV_NUM_W-1:0] nq_i;
    logic [DIV_DEN_W-1:0] den_i;
    logic [DIV_DEN_W:0]   trial;
    if (en) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        if (i == 0) begin
          rem_i = '0;
          nq_i  = num;
          den_i = den;
        end else begin
          rem_i = rem_r[i-1];
          nq_i  = nq_r[i-1];
          den_i = den_r[i-1];
        end
        trial = {rem_i, nq_i[DIV_NUM_W-1]};
        if (trial >= {1'b0, den_i}) begin
          trial    = trial - {1'b0, den_i};
          nq_r[i]  <= {nq_i[DIV_NUM_W-2:0], 1'b1};
        end else begin
          nq_r[i]  <= {nq_i[DIV_NUM_W-2:0], 1'b0};
        end
        rem_r[i] <= trial[DIV_DEN_W-1:0];
        den_r[i] <= den_i;
      end
    end
  end

  assign quo = nq_r[DIV_STEPS-1][CNT_W-1:0];

endmodule

// ===== hw/rtl/temporal_pixel_accumulator.sv =====
// ----------------------------------------------------------------------------
// temporal_pixel_accumulator
// Temporal accumulation of a raster pixel stream with normal and depth
// based rejection of the per-pixel history.
//
// Pixels enter on the in_ channel in raster order, one word per pixel, and
// one result word leaves on the out_ channel for each, in the same order.
// The block takes one pixel per cycle unless a result stall or a history
// hazard holds it. An accepted pixel passes two test stages, an 18-stage
// rounding divider per color channel and the output register on its way to
// out_valid; the history read is issued at the accepting edge itself.
// The history store is read when a pixel enters and written when it leaves;
// a pixel whose entry is still in flight waits at the input.
// The user writes registers on the cfg_ port only while the block is idle;
// the block does not enforce it. A write of frame_pixels, a start_fresh
// pixel or reset make the next frame a first frame. After reset the store
// content is unused until written. When out_stall is high with a result
// waiting, the whole pipeline holds and in_stall rises.
// ----------------------------------------------------------------------------
module temporal_pixel_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_start_fresh,
  input  logic [tpa_pkg::COLOR_W-1:0]         in_color_red,
  input  logic [tpa_pkg::COLOR_W-1:0]         in_color_green,
  input  logic [tpa_pkg::COLOR_W-1:0]         in_color_blue,
  input  logic                                in_guides_present,
  input  logic signed [tpa_pkg::NORM_W-1:0]   in_normal_x,
  input  logic signed [tpa_pkg::NORM_W-1:0]   in_normal_y,
  input  logic signed [tpa_pkg::NORM_W-1:0]   in_normal_z,
  input  logic [tpa_pkg::DEPTH_W-1:0]         in_depth,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tpa_pkg::COLOR_W-1:0]         out_red,
  output logic [tpa_pkg::COLOR_W-1:0]         out_green,
  output logic [tpa_pkg::COLOR_W-1:0]         out_blue,
  output logic                                out_history_accepted,
  output logic [tpa_pkg::CNT_W-1:0]           out_sample_count,
  output logic                                out_last_of_frame,
  input  logic                                cfg_wr_en,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpa_pkg::CFG_W-1:0]           cfg_data
);
  import tpa_pkg::*;

  guide_cfg_t           gcfg_r;
  logic [FRAME_W-1:0]   frame_pixels_r;
  logic [ADDR_W-1:0]    pix_pos_r;
  logic                 hist_valid_r;
  logic                 a_valid_r;
  pix_t                 a_pix_r;
  logic                 d_valid_r [DIV_STEPS];
  side_t                d_side_r  [DIV_STEPS];
  logic                 out_valid_r;
  logic [COLOR_W-1:0]   out_red_r, out_green_r, out_blue_r;
  logic                 out_acc_r, out_last_r;
  logic [CNT_W-1:0]     out_cnt_r;

  logic                 advance, hazard, accept;
  logic [FRAME_W-1:0]   n, p_next;
  logic [ADDR_W-1:0]    pos_base, p;
  logic                 last, hv;
  pix_t                 cur_pix;
  hist_entry_t          rd_data, wr_data;
  stage_tag_t           tag_b;
  logic                 c_vld;
  blend_t               c_res;
  side_t                side_in;
  logic [DIV_NUM_W-1:0] num_r, num_g, num_b;
  logic [DIV_DEN_W-1:0] den;
  logic [CNT_W-1:0]     q_r, q_g, q_b;
  logic [COLOR_W-1:0]   res_r, res_g, res_b;
  side_t                d_end;

  // Front end: pixel position, frame length and the history flag.
  always_comb begin
    if (frame_pixels_r == 0) begin
      n = FRAME_W'(1);
    end else if (frame_pixels_r > FRAME_W'(PIXELS_MAX)) begin
      n = FRAME_W'(PIXELS_MAX);
    end else begin
      n = frame_pixels_r;
    end
    pos_base = in_start_fresh ? '0 : pix_pos_r;
    p        = ({1'b0, pos_base} >= n) ? '0 : pos_base;
    p_next   = {1'b0, p} + FRAME_W'(1);
    last     = p_next >= n;
    hv       = in_start_fresh ? 1'b0 : hist_valid_r;
    cur_pix.addr   = p;
    cur_pix.last   = last;
    cur_pix.hv     = hv;
    cur_pix.red    = in_color_red;
    cur_pix.green  = in_color_green;
    cur_pix.blue   = in_color_blue;
    cur_pix.nx     = in_normal_x;
    cur_pix.ny     = in_normal_y;
    cur_pix.nz     = in_normal_z;
    cur_pix.depth  = in_depth;
    cur_pix.guides = in_guides_present;
  end

  // A pixel waits while any in-flight pixel still owns its history entry.
  always_comb begin
    hazard = (a_valid_r && (a_pix_r.addr == p)) ||
             (tag_b.valid && (tag_b.addr == p)) ||
             (c_vld && (c_res.pix.addr == p));
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (d_valid_r[i] && (d_side_r[i].pix.addr == p)) begin
        hazard = 1'b1;
      end
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance || hazard;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcfg_r.hist_limit       <= RST_HIST_LIMIT;
      gcfg_r.normal_threshold <= RST_NORMAL_THRESHOLD;
      gcfg_r.depth_tolerance  <= RST_DEPTH_TOLERANCE;
      frame_pixels_r          <= RST_FRAME_PIXELS;
      pix_pos_r               <= '0;
      hist_valid_r            <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HIST_LIMIT:       gcfg_r.hist_limit       <= cfg_data[CNT_W-1:0];
        REG_NORMAL_THRESHOLD: gcfg_r.normal_threshold <= cfg_data[NORM_W-1:0];
        REG_DEPTH_TOLERANCE:  gcfg_r.depth_tolerance  <= cfg_data[CNT_W-1:0];
        REG_FRAME_PIXELS: begin
          frame_pixels_r <= cfg_data[FRAME_W-1:0];
          pix_pos_r      <= '0;
          hist_valid_r   <= 1'b0;
        end
        default: ;
      endcase
    end else if (accept) begin
      pix_pos_r    <= last ? '0 : p_next[ADDR_W-1:0];
      hist_valid_r <= last ? 1'b1 : hv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_pix_r <= cur_pix;
    end
  end

  tpa_history_ram u_ram (
    .clk     (clk),
    .rd_en   (advance),
    .rd_addr (p),
    .rd_data (rd_data),
    .wr_en   (advance && d_valid_r[DIV_STEPS-1]),
    .wr_addr (d_end.pix.addr),
    .wr_data (wr_data)
  );

  tpa_guide_test u_guide (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .in_vld  (a_valid_r),
    .in_pix  (a_pix_r),
    .in_hist (rd_data),
    .cfg     (gcfg_r),
    .tag_b   (tag_b),
    .res_vld (c_vld),
    .res     (c_res)
  );

  // Rejected history blends with itself: base is the current color, step 0.
  always_comb begin
    side_in.pix    = c_res.pix;
    side_in.accept = c_res.accept;
    side_in.count  = c_res.count;
    side_in.bred   = c_res.accept ? c_res.hred   : c_res.pix.red;
    side_in.bgreen = c_res.accept ? c_res.hgreen : c_res.pix.green;
    side_in.bblue  = c_res.accept ? c_res.hblue  : c_res.pix.blue;
    side_in.dir[0] = c_res.pix.red   < side_in.bred;
    side_in.dir[1] = c_res.pix.green < side_in.bgreen;
    side_in.dir[2] = c_res.pix.blue  < side_in.bblue;
    num_r = {1'b0, (side_in.dir[0] ? side_in.bred - c_res.pix.red
                                   : c_res.pix.red - side_in.bred), 1'b0}
            + {2'b0, c_res.count};
    num_g = {1'b0, (side_in.dir[1] ? side_in.bgreen - c_res.pix.green
                                   : c_res.pix.green - side_in.bgreen), 1'b0}
            + {2'b0, c_res.count};
    num_b = {1'b0, (side_in.dir[2] ? side_in.bblue - c_res.pix.blue
                                   : c_res.pix.blue - side_in.bblue), 1'b0}
            + {2'b0, c_res.count};
    den   = {c_res.count, 1'b0};
  end

  tpa_divider u_div_r (.clk(clk), .en(advance), .num(num_r), .den(den), .quo(q_r));
  tpa_divider u_div_g (.clk(clk), .en(advance), .num(num_g), .den(den), .quo(q_g));
  tpa_divider u_div_b (.clk(clk), .en(advance), .num(num_b), .den(den), .quo(q_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        d_valid_r[i] <= 1'b0;
      end
    end else if (advance) begin
      d_valid_r[0] <= c_vld;
      for (int i = 1; i < DIV_STEPS; i++) begin
        d_valid_r[i] <= d_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d_side_r[0] <= side_in;
      for (int i = 1; i < DIV_STEPS; i++) begin
        d_side_r[i] <= d_side_r[i-1];
      end
    end
  end

  always_comb begin
    d_end = d_side_r[DIV_STEPS-1];
    res_r = d_end.dir[0] ? d_end.bred   - q_r : d_end.bred   + q_r;
    res_g = d_end.dir[1] ? d_end.bgreen - q_g : d_end.bgreen + q_g;
    res_b = d_end.dir[2] ? d_end.bblue  - q_b : d_end.bblue  + q_b;
    wr_data.red     = res_r;
    wr_data.green   = res_g;
    wr_data.blue    = res_b;
    wr_data.nx      = d_end.pix.nx;
    wr_data.ny      = d_end.pix.ny;
    wr_data.nz      = d_end.pix.nz;
    wr_data.depth   = d_end.pix.depth;
    wr_data.guides  = d_end.pix.guides;
    wr_data.samples = d_end.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= d_valid_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_red_r   <= res_r;
      out_green_r <= res_g;
      out_blue_r  <= res_b;
      out_acc_r   <= d_end.accept;
      out_cnt_r   <= d_end.count;
      out_last_r  <= d_end.pix.last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_red              = out_red_r;
  assign out_green            = out_green_r;
  assign out_blue             = out_blue_r;
  assign out_history_accepted = out_acc_r;
  assign out_sample_count     = out_cnt_r;
  assign out_last_of_frame    = out_last_r;

endmodule

// ===== test/temporal_pixel_accumulator_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_pixel_accumulator_chk
// Watches the pixel, result and register ports of the temporal pixel
// accumulator. It keeps its own copy of the per-pixel history and the
// registers, predicts each result word and compares it with the one that
// leaves the block.
// ----------------------------------------------------------------------------
module temporal_pixel_accumulator_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_start_fresh,
  input  logic [tpa_pkg::COLOR_W-1:0]       in_color_red,
  input  logic [tpa_pkg::COLOR_W-1:0]       in_color_green,
  input  logic [tpa_pkg::COLOR_W-1:0]       in_color_blue,
  input  logic                              in_guides_present,
  input  logic signed [tpa_pkg::NORM_W-1:0] in_normal_x,
  input  logic signed [tpa_pkg::NORM_W-1:0] in_normal_y,
  input  logic signed [tpa_pkg::NORM_W-1:0] in_normal_z,
  input  logic [tpa_pkg::DEPTH_W-1:0]       in_depth,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [tpa_pkg::COLOR_W-1:0]       out_red,
  input  logic [tpa_pkg::COLOR_W-1:0]       out_green,
  input  logic [tpa_pkg::COLOR_W-1:0]       out_blue,
  input  logic                              out_history_accepted,
  input  logic [tpa_pkg::CNT_W-1:0]         out_sample_count,
  input  logic                              out_last_of_frame,
  input  logic                              cfg_wr_en,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpa_pkg::CFG_W-1:0]         cfg_data,
  output int                                fail_count,
  output int                                pending_results
);
  import tpa_pkg::*;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               accepted;
    logic [CNT_W-1:0]   samples;
    logic               last;
  } blended_t;

  hist_entry_t        history_store [int];
  blended_t           blended_q [$];
  logic               history_ok;
  int unsigned        position;
  logic [CNT_W-1:0]   hist_limit;
  logic [NORM_W-1:0]  normal_thr;
  logic [CNT_W-1:0]   depth_tol;
  logic [FRAME_W-1:0] frame_pixels;

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [COLOR_W-1:0] blend_toward(logic [COLOR_W-1:0] hv,
                                                      logic [COLOR_W-1:0] cv, int cnt);
    longint mag, q;
    if (cv >= hv) begin
      mag = cv - hv;
      q = (2 * mag + cnt) / (2 * cnt);
      return COLOR_W'(hv + q);
    end
    mag = hv - cv;
    q = (2 * mag + cnt) / (2 * cnt);
    return COLOR_W'(hv - q);
  endfunction

  task automatic accumulate_pixel();
    hist_entry_t old, upd;
    blended_t    res;
    int unsigned n, p;
    logic        accept, cn, hn;
    longint      dot, thr, diff, mx, cd, hd;
    int          cnt, maxh;
    if (in_start_fresh) begin
      history_ok = 1'b0;
      position = 0;
    end
    n = (frame_pixels == 0) ? 1 :
        ((frame_pixels > PIXELS_MAX) ? PIXELS_MAX : int'(frame_pixels));
    if (position >= n) position = 0;
    p = position;
    accept = 1'b0;
    old = '0;
    if (history_ok && in_guides_present && history_store.exists(p)) begin
      old = history_store[p];
      if (old.guides) begin
        accept = 1'b1;
        cn = (in_normal_x != 0) || (in_normal_y != 0) || (in_normal_z != 0);
        hn = (old.nx != 0) || (old.ny != 0) || (old.nz != 0);
        if (cn && hn) begin
          dot = longint'($signed(in_normal_x)) * longint'($signed(old.nx)) +
                longint'($signed(in_normal_y)) * longint'($signed(old.ny)) +
                longint'($signed(in_normal_z)) * longint'($signed(old.nz));
          thr = longint'($signed(normal_thr));
          if (thr < -16384) thr = -16384;
          if (thr > 16384) thr = 16384;
          accept = dot >= thr * 16384;
        end
        cd = in_depth;
        hd = old.depth;
        if (cd != 0 && hd != 0) begin
          diff = (cd > hd) ? cd - hd : hd - cd;
          mx = (cd > hd) ? cd : hd;
          if ((diff << 12) > longint'(depth_tol) * mx) accept = 1'b0;
        end
      end
    end
    if (accept) begin
      maxh = (hist_limit == 0) ? 1 : int'(hist_limit);
      cnt = int'(old.samples) + 1;
      if (cnt > maxh) cnt = maxh;
      res.red = blend_toward(old.red, in_color_red, cnt);
      res.green = blend_toward(old.green, in_color_green, cnt);
      res.blue = blend_toward(old.blue, in_color_blue, cnt);
    end else begin
      cnt = 1;
      res.red = in_color_red;
      res.green = in_color_green;
      res.blue = in_color_blue;
    end
    upd.red = res.red;
    upd.green = res.green;
    upd.blue = res.blue;
    upd.nx = in_normal_x;
    upd.ny = in_normal_y;
    upd.nz = in_normal_z;
    upd.depth = in_depth;
    upd.guides = in_guides_present;
    upd.samples = CNT_W'(cnt);
    history_store[p] = upd;
    res.accepted = accept;
    res.samples = CNT_W'(cnt);
    res.last = (p + 1 >= n);
    if (res.last) begin
      position = 0;
      history_ok = 1'b1;
    end else begin
      position = p + 1;
    end
    blended_q.insert(blended_q.size(), res);
  endtask

  task automatic compare_result();
    blended_t want;
    if (blended_q.size() == 0) begin
      report_mismatch("result word with nothing expected");
      return;
    end
    want = blended_q.pop_front();
    if (out_red !== want.red)
      report_mismatch($sformatf("red %0h, want %0h", out_red, want.red));
    if (out_green !== want.green)
      report_mismatch($sformatf("green %0h, want %0h", out_green, want.green));
    if (out_blue !== want.blue)
      report_mismatch($sformatf("blue %0h, want %0h", out_blue, want.blue));
    if (out_history_accepted !== want.accepted)
      report_mismatch($sformatf("history_accepted %0b, want %0b",
                                out_history_accepted, want.accepted));
    if (out_sample_count !== want.samples)
      report_mismatch($sformatf("sample_count %0d, want %0d",
                                out_sample_count, want.samples));
    if (out_last_of_frame !== want.last)
      report_mismatch($sformatf("last_of_frame %0b, want %0b",
                                out_last_of_frame, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      history_store.delete();
      blended_q.delete();
      history_ok = 1'b0;
      position = 0;
      hist_limit = RST_HIST_LIMIT;
      normal_thr = RST_NORMAL_THRESHOLD;
      depth_tol = RST_DEPTH_TOLERANCE;
      frame_pixels = RST_FRAME_PIXELS;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_HIST_LIMIT: hist_limit = cfg_data[CNT_W-1:0];
          REG_NORMAL_THRESHOLD: normal_thr = cfg_data[NORM_W-1:0];
          REG_DEPTH_TOLERANCE: depth_tol = cfg_data[CNT_W-1:0];
          REG_FRAME_PIXELS: begin
            frame_pixels = cfg_data[FRAME_W-1:0];
            history_ok = 1'b0;
            position = 0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_result();
      if (in_valid && !in_stall) accumulate_pixel();
    end
    pending_results <= blended_q.size();
  end

endmodule

// ===== test/temporal_pixel_accumulator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_pixel_accumulator_tb
// Drives pixel frames through the temporal pixel accumulator under a series
// of register settings, with random gaps and result stalls, and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module temporal_pixel_accumulator_tb;
  import tpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_start_fresh = 1'b0;
  logic [COLOR_W-1:0]  in_color_red = '0;
  logic [COLOR_W-1:0]  in_color_green = '0;
  logic [COLOR_W-1:0]  in_color_blue = '0;
  logic                in_guides_present = 1'b0;
  logic signed [NORM_W-1:0] in_normal_x = '0;
  logic signed [NORM_W-1:0] in_normal_y = '0;
  logic signed [NORM_W-1:0] in_normal_z = '0;
  logic [DEPTH_W-1:0]  in_depth = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;
  logic                out_history_accepted;
  logic [CNT_W-1:0]    out_sample_count;
  logic                out_last_of_frame;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  int                  fail_count;
  int                  pending_results;
  int                  idle_pct = 36;
  int                  quiet_cycles = 0;

  int                  scene_nx [64];
  int                  scene_ny [64];
  int                  scene_nz [64];
  int                  scene_depth [64];
  int                  frame_len = PIXELS_MAX;
  int                  pixel_idx = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  temporal_pixel_accumulator dut (.*);

  temporal_pixel_accumulator_chk chk (.*);

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < idle_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic sf, int r, int g, int b, logic gp,
                           int nx, int ny, int nz, int d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_fresh <= sf;
    in_color_red <= COLOR_W'(r);
    in_color_green <= COLOR_W'(g);
    in_color_blue <= COLOR_W'(b);
    in_guides_present <= gp;
    in_normal_x <= NORM_W'(nx);
    in_normal_y <= NORM_W'(ny);
    in_normal_z <= NORM_W'(nz);
    in_depth <= DEPTH_W'(d);
    do @(posedge clk); while (in_stall);
    if (sf) pixel_idx = 0;
    pixel_idx = (pixel_idx + 1) % frame_len;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_frame(int val);
    write_reg(REG_FRAME_PIXELS, CFG_W'(val));
    frame_len = (val == 0) ? 1 : ((val > PIXELS_MAX) ? PIXELS_MAX : val);
    pixel_idx = 0;
  endtask

  task automatic random_pixel();
    int  kind, s;
    logic sf;
    kind = $urandom_range(99);
    sf = ($urandom_range(99) < 2);
    s = (sf ? 0 : pixel_idx) % 64;
    if (kind < 80) begin
      send_word(sf, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535), 1'b1,
                scene_nx[s] + $urandom_range(600) - 300,
                scene_ny[s] + $urandom_range(600) - 300,
                scene_nz[s], scene_depth[s] + $urandom_range(64) - 32);
    end else if (kind < 95) begin
      send_word(sf, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                $urandom_range(1),
                ($urandom_range(3) == 0) ? 0 : $urandom_range(32768) - 16384,
                ($urandom_range(3) == 0) ? 0 : $urandom_range(32768) - 16384,
                ($urandom_range(3) == 0) ? 0 : $urandom_range(32768) - 16384,
                ($urandom_range(3) == 0) ? 0 : $urandom_range(24'hFFFFFF));
    end else begin
      scene_nx[s] = $urandom_range(4000) - 2000;
      scene_ny[s] = $urandom_range(4000) - 2000;
      scene_nz[s] = ($urandom_range(1) == 1) ? 16000 : -16000;
      scene_depth[s] = $urandom_range(24'hFFF000, 24'h100);
      send_word(sf, $urandom_range(65535), $urandom_range(65535), $urandom_range(65535), 1'b1,
                scene_nx[s], scene_ny[s], scene_nz[s], scene_depth[s]);
    end
  endtask

  task automatic run_setting(int mh, int thr, int tol, int fp, int items);
    write_reg(REG_HIST_LIMIT, CFG_W'(mh));
    write_reg(REG_NORMAL_THRESHOLD, CFG_W'(thr));
    write_reg(REG_DEPTH_TOLERANCE, CFG_W'(tol));
    set_frame(fp);
    repeat (items) random_pixel();
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      scene_nx[i] = $urandom_range(2000) - 1000;
      scene_ny[i] = $urandom_range(2000) - 1000;
      scene_nz[i] = 16000;
      scene_depth[i] = $urandom_range(24'hFFF000, 24'h100);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First frame after reset: colors pass through.
    send_word(1'b0, 16'hFFFF, 16'h0000, 16'h8000, 1'b1, 16384, -16384, 0, 24'hFFFFFF);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0, -16384, 16384, 16384, 0);
    send_word(1'b1, 16'h1234, 16'hABCD, 16'h5555, 1'b1, 0, 0, 0, 1);
    drain_results();

    set_frame(4);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'h0100, 1'b1, 0, 0, 16384, 24'h001000);
    send_word(1'b0, 16'hFFFF, 16'h0000, 16'h0101, 1'b1, 0, 0, 0, 0);
    send_word(1'b0, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16384, 0, 0, 24'hFFFFFF);
    send_word(1'b0, 16'h4000, 16'h4000, 16'h4000, 1'b0, 0, 16384, 0, 24'h000100);
    // Same pixels again: accept with equal normal, accept with no normal,
    // reject with opposite normal, reject for missing guides.
    send_word(1'b0, 16'hFFFF, 16'h0000, 16'h0103, 1'b1, 0, 0, 16384, 24'h001001);
    send_word(1'b0, 16'h0000, 16'hFFFF, 16'h0100, 1'b1, 16384, 0, 0, 24'h000001);
    send_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, -16384, 0, 0, 24'hFFFFFF);
    send_word(1'b0, 16'h1111, 16'h2222, 16'h3333, 1'b1, 0, 16384, 0, 24'h000100);
    // Depth far off rejects; then a start fresh pixel drops the history.
    send_word(1'b0, 16'h0001, 16'h0002, 16'h0003, 1'b1, 0, 0, 16384, 24'h800000);
    send_word(1'b1, 16'h0004, 16'h0005, 16'h0006, 1'b1, 0, 0, 16384, 24'h001001);
    drain_results();

    run_setting(32, 14746, 410, 7, 60);
    idle_pct = 0;
    run_setting(1, 17'h18000, 0, 1, 40);
    idle_pct = 36;
    run_setting(0, 17'h17FFF, 17'h1FFFF, 16, 70);
    run_setting(65535, 0, 4096, 3, 60);
    run_setting(5, 17'h0FC18, 200, 0, 30);
    run_setting(3, 14746, 410, 17'h1FFFF, 12);
    run_setting(2, 16384, 65535, 40, 90);
    run_setting(17'h1FFFF, -16384 & 17'h1FFFF, 2000, 9, 60);

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tpa_pkg.sv
hw/rtl/tpa_history_ram.sv
hw/rtl/tpa_guide_test.sv
hw/rtl/tpa_divider.sv
hw/rtl/temporal_pixel_accumulator.sv
test/temporal_pixel_accumulator_chk.sv
test/temporal_pixel_accumulator_tb.sv
